// ----- hw/rtl/snaparr_pkg.sv -----
// ----------------------------------------------------------------------------
// snaparr_pkg
// Shared sizes, operation codes and sequencer states for the snapshot array.
// ----------------------------------------------------------------------------
package snaparr_pkg;

    localparam int ARRAY_LENGTH  = 256;
    localparam int HISTORY_DEPTH = 8;
    localparam int SNAP_BITS     = 16;
    localparam int VALUE_BITS    = 32;

    localparam int IDX_BITS    = $clog2(ARRAY_LENGTH);
    localparam int SLOT_BITS   = $clog2(HISTORY_DEPTH);
    localparam int CNT_BITS    = $clog2(HISTORY_DEPTH + 1);
    localparam int STORE_DEPTH = ARRAY_LENGTH * HISTORY_DEPTH;
    localparam int ADDR_BITS   = IDX_BITS + SLOT_BITS;
    localparam int HIST_BITS   = SNAP_BITS + VALUE_BITS;

    // stream payload layout
    localparam int FUNC_BITS   = 2;
    localparam int S_DATA_BITS = 56;   // index, value, snap_id
    localparam int M_DATA_BITS = 56;   // read_value, snap_number, full_flag
    localparam int M_PAD_BITS  = M_DATA_BITS - (VALUE_BITS + SNAP_BITS + 1);

    localparam logic [SNAP_BITS-1:0] SNAP_MAX = '1;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_SET  = 2'd0,
        FUNC_SNAP = 2'd1,
        FUNC_GET  = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SET_EVAL,
        ST_GET_ISSUE,
        ST_GET_CMP,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/snapshot_versioned_array.sv -----
// ----------------------------------------------------------------------------
// snapshot_versioned_array
// Per-index history of (value, snap) pairs with snapshot and versioned get.
// ----------------------------------------------------------------------------
// From accept to result: a snap or unknown op goes straight to the done state; a
// set reads the fill count, checks the newest entry and writes; a get reads the
// fill count, then runs k binary-search probes (k <= 4 at a history depth of 8).
// Each probe is one RAM read issue and one compare. One request in flight: the
// next is taken in the idle cycle after the result issues; a stalled output holds done.
// Reset clears the snap counter and per-index valid bits; history RAM is not reset.
// ----------------------------------------------------------------------------
module snapshot_versioned_array (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: [7:0] index, [39:8] value, [55:40] snap_id
    input  logic [snaparr_pkg::S_DATA_BITS-1:0] s_tdata,
    // s_tuser: [1:0] func
    input  logic [snaparr_pkg::FUNC_BITS-1:0]   s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // m_tdata: [31:0] read_value, [47:32] snap_number, [48] full_flag,
    //          [55:49] zero
    output logic [snaparr_pkg::M_DATA_BITS-1:0] m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready
);

    import snaparr_pkg::*;

    state_t                  state_reg, state_next;
    func_t                   func_reg, func_next;
    logic [IDX_BITS-1:0]     idx_reg, idx_next;
    logic [VALUE_BITS-1:0]   val_reg, val_next;
    logic [SNAP_BITS-1:0]    sid_reg, sid_next;
    logic [SNAP_BITS-1:0]    snap_cnt_reg, snap_cnt_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic [CNT_BITS-1:0]     lo_reg, lo_next;
    logic [CNT_BITS-1:0]     hi_reg, hi_next;
    logic [VALUE_BITS-1:0]   ans_reg, ans_next;
    logic [SNAP_BITS-1:0]    res_sn_reg, res_sn_next;
    logic                    res_full_reg, res_full_next;
    logic [ARRAY_LENGTH-1:0] cnt_valid_reg, cnt_valid_next;
    logic                    m_valid_reg, m_valid_next;
    logic [M_DATA_BITS-1:0]  m_data_reg, m_data_next;

    logic [IDX_BITS-1:0]   s_index;
    logic [VALUE_BITS-1:0] s_value;
    logic [SNAP_BITS-1:0]  s_snap_id;

    logic                  hist_we;
    logic [ADDR_BITS-1:0]  hist_wr_addr, hist_rd_addr;
    logic [HIST_BITS-1:0]  hist_wdata, hist_rdata;
    logic                  cnt_we;
    logic [CNT_BITS-1:0]   cnt_wdata, cnt_rdata;

    logic [CNT_BITS-1:0]   cur_cnt, last_slot, mid;
    logic [CNT_BITS:0]     mid_sum;
    logic [SNAP_BITS-1:0]  hist_snap;
    logic [VALUE_BITS-1:0] hist_val;

    assign s_index   = s_tdata[IDX_BITS-1:0];
    assign s_value   = s_tdata[IDX_BITS +: VALUE_BITS];
    assign s_snap_id = s_tdata[IDX_BITS + VALUE_BITS +: SNAP_BITS];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // history entries: {snap, value}, row per index
    snaparr_ram #(
        .WIDTH (HIST_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (hist_we),
        .wr_addr (hist_wr_addr),
        .wr_data (hist_wdata),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_rdata)
    );

    // fill count per index; qualified by cnt_valid_reg
    snaparr_ram #(
        .WIDTH (CNT_BITS),
        .DEPTH (ARRAY_LENGTH)
    ) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (cnt_we),
        .wr_addr (idx_reg),
        .wr_data (cnt_wdata),
        .rd_addr (s_index),
        .rd_data (cnt_rdata)
    );

    assign hist_snap = hist_rdata[VALUE_BITS +: SNAP_BITS];
    assign hist_val  = hist_rdata[VALUE_BITS-1:0];
    assign cur_cnt   = cnt_valid_reg[idx_reg] ? cnt_rdata : '0;
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[CNT_BITS:1];
    assign hist_wdata = {snap_cnt_reg, val_reg};

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        sid_next       = sid_reg;
        snap_cnt_next  = snap_cnt_reg;
        cnt_next       = cnt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        ans_next       = ans_reg;
        res_sn_next    = res_sn_reg;
        res_full_next  = res_full_reg;
        cnt_valid_next = cnt_valid_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        hist_we      = 1'b0;
        hist_wr_addr = {idx_reg, cnt_reg[SLOT_BITS-1:0]};
        hist_rd_addr = {idx_reg, mid[SLOT_BITS-1:0]};
        cnt_we       = 1'b0;
        cnt_wdata    = cnt_reg + 1'b1;
        last_slot    = cur_cnt - 1'b1;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next     = func_t'(s_tuser);
                    idx_next      = s_index;
                    val_next      = s_value;
                    sid_next      = s_snap_id;
                    ans_next      = '0;
                    res_sn_next   = '0;
                    res_full_next = 1'b0;
                    case (func_t'(s_tuser))
                        FUNC_SET, FUNC_GET: begin
                            state_next = ST_COUNT;
                        end
                        FUNC_SNAP: begin
                            res_sn_next = snap_cnt_reg;
                            if (snap_cnt_reg == SNAP_MAX) begin
                                res_full_next = 1'b1;
                            end else begin
                                snap_cnt_next = snap_cnt_reg + 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_COUNT: begin
                cnt_next = cur_cnt;
                if (func_reg == FUNC_SET) begin
                    // fetch the newest entry to check its epoch
                    hist_rd_addr = {idx_reg, last_slot[SLOT_BITS-1:0]};
                    state_next   = ST_SET_EVAL;
                end else begin
                    lo_next    = '0;
                    hi_next    = cur_cnt;
                    state_next = ST_GET_ISSUE;
                end
            end
            ST_SET_EVAL: begin
                if (cnt_reg != '0 && hist_snap == snap_cnt_reg) begin
                    last_slot    = cnt_reg - 1'b1;
                    hist_we      = 1'b1;
                    hist_wr_addr = {idx_reg, last_slot[SLOT_BITS-1:0]};
                end else if (cnt_reg < CNT_BITS'(HISTORY_DEPTH)) begin
                    hist_we                 = 1'b1;
                    cnt_we                  = 1'b1;
                    cnt_valid_next[idx_reg] = 1'b1;
                end else begin
                    res_full_next = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_GET_ISSUE: begin
                if (lo_reg < hi_reg) begin
                    state_next = ST_GET_CMP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_GET_CMP: begin
                // lo/hi unchanged since issue, so mid is the probed slot
                if (hist_snap <= sid_reg) begin
                    ans_next = hist_val;
                    lo_next  = mid + 1'b1;
                end else begin
                    hi_next = mid;
                end
                state_next = ST_GET_ISSUE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{M_PAD_BITS{1'b0}}, res_full_reg, res_sn_reg, ans_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            snap_cnt_reg  <= '0;
            cnt_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            snap_cnt_reg  <= snap_cnt_next;
            cnt_valid_reg <= cnt_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        sid_reg      <= sid_next;
        cnt_reg      <= cnt_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        ans_reg      <= ans_next;
        res_sn_reg   <= res_sn_next;
        res_full_reg <= res_full_next;
        m_data_reg   <= m_data_next;
    end

    // a request always leaves idle
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after a request");

    // snap counter moves by one on a non-saturated snap, and only then
    a_snap_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == FUNC_SNAP && snap_cnt_reg != SNAP_MAX)
        |=> (snap_cnt_reg == $past(snap_cnt_reg) + 1'b1))
        else $error("snap counter did not advance");

    a_snap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tvalid && s_tready && s_tuser == FUNC_SNAP) |=> $stable(snap_cnt_reg))
        else $error("snap counter changed without a snap");

    // a probe is only compared inside a non-empty search window
    a_probe_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GET_CMP) |-> (lo_reg < hi_reg && hi_reg <= CNT_BITS'(HISTORY_DEPTH)))
        else $error("binary search probe outside its window");

    // a finished result is not dropped while the output is stalled
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result left done state while output stalled");

endmodule

// ----- hw/rtl/snaparr_ram.sv -----
// ----------------------------------------------------------------------------
// snaparr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module snaparr_ram #(
    parameter int WIDTH     = 8,
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- bench/snaparr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snaparr_checker
// Watches both stream channels of the snapshot array and keeps its own copy
// of the per-index histories and the snap counter. Each accepted request is
// predicted on the spot; each accepted result is compared field by field with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module snaparr_checker
    import snaparr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [S_DATA_BITS-1:0] s_tdata,
    input  logic [FUNC_BITS-1:0]   s_tuser,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [M_DATA_BITS-1:0] m_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    output int                     fail_count,
    output int                     outstanding
);

    // laid out to match m_tdata, lowest field last
    typedef struct packed {
        logic [M_PAD_BITS-1:0] pad;
        logic                  full_flag;
        logic [SNAP_BITS-1:0]  snap_number;
        logic [VALUE_BITS-1:0] read_value;
    } snap_result_t;

    logic [VALUE_BITS-1:0] hist_value [ARRAY_LENGTH][HISTORY_DEPTH];
    logic [SNAP_BITS-1:0]  hist_snap  [ARRAY_LENGTH][HISTORY_DEPTH];
    int unsigned           hist_count [ARRAY_LENGTH];
    logic [SNAP_BITS-1:0]  snap_ctr;
    snap_result_t          awaited_results [$];
    snap_result_t          got;
    snap_result_t          want;
    snap_result_t          owed;
    int                    errors;

    // Applies one request to the shadow array and returns the result it owes.
    function automatic snap_result_t predict_snap_op(
        input func_t                 op,
        input logic [IDX_BITS-1:0]   idx,
        input logic [VALUE_BITS-1:0] val,
        input logic [SNAP_BITS-1:0]  view
    );
        snap_result_t r;
        int unsigned  n;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        r = '0;
        n = hist_count[idx];
        case (op)
            FUNC_SET: begin
                if (n > 0 && hist_snap[idx][n-1] == snap_ctr) begin
                    hist_value[idx][n-1] = val;
                end else if (n < HISTORY_DEPTH) begin
                    hist_value[idx][n] = val;
                    hist_snap[idx][n]  = snap_ctr;
                    hist_count[idx]    = n + 1;
                end else begin
                    r.full_flag = 1'b1;
                end
            end
            FUNC_SNAP: begin
                r.snap_number = snap_ctr;
                if (snap_ctr == SNAP_MAX)
                    r.full_flag = 1'b1;
                else
                    snap_ctr = snap_ctr + 1'b1;
            end
            FUNC_GET: begin
                // newest entry with snap <= view, search range [lo, hi)
                lo = 0;
                hi = n;
                while (lo < hi) begin
                    mid = (lo + hi) / 2;
                    if (hist_snap[idx][mid] <= view) begin
                        r.read_value = hist_value[idx][mid];
                        lo = mid + 1;
                    end else begin
                        hi = mid;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (hist_count[i])
                hist_count[i] = 0;
            snap_ctr = '0;
            awaited_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = snap_result_t'(m_tdata);
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with no request pending, expected none, actual %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("read_value", 64'(want.read_value), 64'(got.read_value));
                    compare_field("snap_number", 64'(want.snap_number),
                                  64'(got.snap_number));
                    compare_field("full_flag", 64'(want.full_flag), 64'(got.full_flag));
                    compare_field("pad", 64'(want.pad), 64'(got.pad));
                end
            end
            if (s_tvalid && s_tready) begin
                owed = predict_snap_op(func_t'(s_tuser),
                    s_tdata[7:0], s_tdata[39:8], s_tdata[55:40]);
                awaited_results = {awaited_results, owed};
            end
        end
        fail_count  <= errors;
        outstanding <= awaited_results.size();
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream stimulus for the snapshot array: a directed opening that fills and
// overflows one history and reads it back, then random requests over four
// idle and stall phases.
// ----------------------------------------------------------------------------
module tb_top;
    import snaparr_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 275;
    localparam int SETTLE_CYCLES = 20;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic [S_DATA_BITS-1:0] s_tdata  = '0;
    logic [FUNC_BITS-1:0]   s_tuser  = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [M_DATA_BITS-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;

    int          fail_count;
    int          outstanding;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned snaps_sent     = 0;
    int          quiet_cycles   = 0;

    always #5 aclk = ~aclk;

    snapshot_versioned_array DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    snaparr_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // no request or result moving for too long means the block is stuck
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the request is taken,
    // leaving tvalid high so a following request goes out back to back.
    task automatic send_op(input func_t op, input logic [IDX_BITS-1:0] idx,
                           input logic [VALUE_BITS-1:0] val,
                           input logic [SNAP_BITS-1:0] sid);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {sid, val, idx};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (op == FUNC_SNAP)
            snaps_sent++;
    endtask

    // sender holds off until every outstanding result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    // Most traffic hits a few indices so histories fill and overflow; gets
    // mostly ask for views around the snaps taken so far.
    task automatic random_op();
        logic [IDX_BITS-1:0]  idx;
        logic [SNAP_BITS-1:0] sid;
        int unsigned          pick;
        func_t                op;
        pick = $urandom_range(99);
        idx  = ($urandom_range(99) < 80) ? IDX_BITS'($urandom_range(15))
                                         : IDX_BITS'($urandom_range(255));
        sid  = ($urandom_range(99) < 60) ? SNAP_BITS'($urandom_range(snaps_sent + 1))
                                         : SNAP_BITS'($urandom);
        if (pick < 40)
            op = FUNC_SET;
        else if (pick < 60)
            op = FUNC_SNAP;
        else if (pick < 97)
            op = FUNC_GET;
        else
            op = FUNC_NONE;
        send_op(op, idx, $urandom, sid);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // index 0: seven epochs, then an eighth entry that fills the history
        for (int k = 0; k < 7; k++) begin
            send_op(FUNC_SET, 8'd0, (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF : $urandom,
                    16'h0);
            send_op(FUNC_SNAP, IDX_BITS'($urandom), $urandom, SNAP_BITS'($urandom));
        end
        send_op(FUNC_SET, 8'd0, $urandom, 16'h0);
        send_op(FUNC_SET, 8'd0, 32'hA5A5_5A5A, 16'h0);   // overwrite when full
        send_op(FUNC_SNAP, 8'd0, 32'h0, 16'h0);
        send_op(FUNC_SET, 8'd0, 32'h1234_5678, 16'h0);   // dropped, full
        send_op(FUNC_GET, 8'd0, 32'h0, 16'd0);
        send_op(FUNC_GET, 8'd0, 32'h0, 16'd3);
        send_op(FUNC_GET, 8'd0, 32'hFFFF_FFFF, 16'd7);
        send_op(FUNC_GET, 8'd0, 32'h0, 16'hFFFF);
        send_op(FUNC_GET, 8'hFF, 32'h0, 16'hFFFF);       // never written
        send_op(FUNC_SET, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(FUNC_GET, 8'hFF, 32'h0, 16'hFFFF);
        send_op(FUNC_NONE, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            repeat (PHASE_ITEMS)
                random_op();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/snaparr_pkg.sv
hw/rtl/snaparr_ram.sv
hw/rtl/snapshot_versioned_array.sv
bench/snaparr_checker.sv
bench/tb_top.sv
